// ----- src/slit_pkg.sv -----
// ----------------------------------------------------------------------------
// slit_pkg
// Shared types and constants for the sorted leaf insert table: sizes, request
// and status codes, register map and the controller state type.
// ----------------------------------------------------------------------------
package slit_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 5;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int ENTRY_W  = KEY_W + VAL_W;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// Register map
	localparam int                CFG_AW               = 3;
	localparam logic [CFG_AW-1:0] REG_ADDR_MAX_ENTRIES = 3'd0;
	localparam logic [CNT_W-1:0]  MAX_ENTRIES_RST      = 5'd16;

	// Request codes
	localparam logic [1:0] REQ_PUT  = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_POP  = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_UPDATED = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_RANGE   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_SHIFT,
		ST_INSERT,
		ST_RDWAIT,
		ST_DONE
	} state_t;

endpackage

// ----- src/slit_ram.sv -----
// ----------------------------------------------------------------------------
// slit_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module slit_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/sorted_leaf_insert_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_leaf_insert_table_core
// Key/value table kept in ascending key order, as in a B+ tree leaf. Put
// updates a present key or inserts in order, read returns an entry, pop
// removes the last entry. Entries live in one RAM of key:value words.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | word
//  ---------+----------------------------+-------------------------------------
//  request  | in_valid / in_ready        | req_type, key, value, index
//  result   | out_valid / out_ready      | status, key_out, value_out, count
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  One request at a time. Pop and bad codes go from idle to done; a read in
//  range passes rdwait. A put searches, decides and, to insert below the end,
//  moves the entries above its position up in shift before insert.
//  Reset clears state, count and out_valid and sets limit 16; no RAM clearing.
//  A new request is taken while a finished word waits in the output register.
// ----------------------------------------------------------------------------
module sorted_leaf_insert_table_core (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] key,
	input  logic [31:0] value,
	input  logic [3:0]  index,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] key_out,
	output logic [31:0] value_out,
	output logic [4:0]  count,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = slit_pkg::ADDR_W;
	localparam int CW = slit_pkg::CNT_W;

	slit_pkg::state_t state_q, state_d;

	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      max_entries_q;
	logic [CW-1:0]      limit;
	logic [31:0]        req_key_q, req_value_q;
	logic [AW-1:0]      scan_q, scan_d;
	logic [CW-1:0]      pos_q, pos_d;
	logic               found_q, found_d;
	logic [1:0]         res_status_q, res_status_d;
	logic [31:0]        res_key_q, res_key_d;
	logic [31:0]        res_value_q, res_value_d;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [31:0]        key_out_q, value_out_q;
	logic [CW-1:0]      count_out_q;
	logic               out_free;
	logic               cfg_wr;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr, ram_raddr;
	logic [slit_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
	logic [31:0]                   rd_key, rd_value;

	slit_ram #(
		.WIDTH(slit_pkg::ENTRY_W),
		.DEPTH(slit_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_key   = ram_rdata[slit_pkg::ENTRY_W-1:slit_pkg::VAL_W];
	assign rd_value = ram_rdata[slit_pkg::VAL_W-1:0];

	assign limit    = (max_entries_q > slit_pkg::CAP_CNT) ? slit_pkg::CAP_CNT : max_entries_q;
	assign in_ready = (state_q == slit_pkg::ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == slit_pkg::REG_ADDR_MAX_ENTRIES);
	assign prdata = (paddr == slit_pkg::REG_ADDR_MAX_ENTRIES) ?
		{{(32-CW){1'b0}}, max_entries_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= slit_pkg::ST_IDLE;
			count_q       <= '0;
			max_entries_q <= slit_pkg::MAX_ENTRIES_RST;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_wr) begin
				max_entries_q <= pwdata[CW-1:0];
			end
			if (state_q == slit_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_key_q   <= key;
			req_value_q <= value;
		end
		scan_q       <= scan_d;
		pos_q        <= pos_d;
		found_q      <= found_d;
		res_status_q <= res_status_d;
		res_key_q    <= res_key_d;
		res_value_q  <= res_value_d;
		if (state_q == slit_pkg::ST_DONE && out_free) begin
			status_q    <= res_status_q;
			key_out_q   <= res_key_q;
			value_out_q <= res_value_q;
			count_out_q <= count_q;
		end
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		scan_d       = scan_q;
		pos_d        = pos_q;
		found_d      = found_q;
		res_status_d = res_status_q;
		res_key_d    = res_key_q;
		res_value_d  = res_value_q;
		ram_we       = 1'b0;
		ram_waddr    = pos_q[AW-1:0];
		ram_wdata    = {req_key_q, req_value_q};
		ram_raddr    = scan_q;

		unique case (state_q)
			slit_pkg::ST_IDLE: begin
				if (in_valid) begin
					res_key_d    = '0;
					res_value_d  = '0;
					res_status_d = slit_pkg::STAT_RANGE;
					unique case (req_type)
						slit_pkg::REQ_PUT: begin
							if (count_q == '0) begin
								pos_d   = '0;
								found_d = 1'b0;
								state_d = slit_pkg::ST_DECIDE;
							end else begin
								ram_raddr = '0;
								scan_d    = '0;
								state_d   = slit_pkg::ST_SEARCH;
							end
						end
						slit_pkg::REQ_READ: begin
							if (CW'(index) < count_q) begin
								ram_raddr = index;
								state_d   = slit_pkg::ST_RDWAIT;
							end else begin
								state_d = slit_pkg::ST_DONE;
							end
						end
						slit_pkg::REQ_POP: begin
							if (count_q != '0) begin
								count_d      = count_q - 1'b1;
								res_status_d = slit_pkg::STAT_DONE;
							end
							state_d = slit_pkg::ST_DONE;
						end
						default: begin
							state_d = slit_pkg::ST_DONE;
						end
					endcase
				end
			end
			slit_pkg::ST_SEARCH: begin
				// rdata holds the entry at scan_q; stop at the first key not below
				if (rd_key >= req_key_q) begin
					pos_d   = CW'(scan_q);
					found_d = (rd_key == req_key_q);
					state_d = slit_pkg::ST_DECIDE;
				end else if (CW'(scan_q) + 1'b1 == count_q) begin
					pos_d   = count_q;
					found_d = 1'b0;
					state_d = slit_pkg::ST_DECIDE;
				end else begin
					ram_raddr = scan_q + 1'b1;
					scan_d    = scan_q + 1'b1;
				end
			end
			slit_pkg::ST_DECIDE: begin
				if (found_q) begin
					ram_we       = 1'b1;
					res_status_d = slit_pkg::STAT_UPDATED;
					state_d      = slit_pkg::ST_DONE;
				end else if (count_q >= limit) begin
					res_status_d = slit_pkg::STAT_FULL;
					state_d      = slit_pkg::ST_DONE;
				end else if (pos_q == count_q) begin
					ram_we       = 1'b1;
					count_d      = count_q + 1'b1;
					res_status_d = slit_pkg::STAT_DONE;
					state_d      = slit_pkg::ST_DONE;
				end else begin
					// open a gap: move entries up from the last one down to pos
					ram_raddr = AW'(count_q - 1'b1);
					scan_d    = AW'(count_q - 1'b1);
					state_d   = slit_pkg::ST_SHIFT;
				end
			end
			slit_pkg::ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = scan_q + 1'b1;
				ram_wdata = ram_rdata;
				if (CW'(scan_q) == pos_q) begin
					state_d = slit_pkg::ST_INSERT;
				end else begin
					ram_raddr = scan_q - 1'b1;
					scan_d    = scan_q - 1'b1;
				end
			end
			slit_pkg::ST_INSERT: begin
				ram_we       = 1'b1;
				count_d      = count_q + 1'b1;
				res_status_d = slit_pkg::STAT_DONE;
				state_d      = slit_pkg::ST_DONE;
			end
			slit_pkg::ST_RDWAIT: begin
				res_key_d    = rd_key;
				res_value_d  = rd_value;
				res_status_d = slit_pkg::STAT_DONE;
				state_d      = slit_pkg::ST_DONE;
			end
			slit_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = slit_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slit_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign key_out   = key_out_q;
	assign value_out = value_out_q;
	assign count     = count_out_q;

endmodule

// ----- src/slit_checker.sv -----
// ----------------------------------------------------------------------------
// slit_checker
// Port-level checks on the sorted leaf insert table, bound to the top level.
// ----------------------------------------------------------------------------
module slit_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] key_out,
	input logic [31:0] value_out,
	input logic [4:0]  count,
	input logic        pready
);

	// count never passes the table capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= slit_pkg::CAP_CNT)
		else $error("count beyond capacity");

	// only a successful read carries key and value
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != slit_pkg::STAT_DONE) |-> (key_out == '0 && value_out == '0))
		else $error("payload not zero on non-read result");

	// an update needs a stored key
	a_update_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == slit_pkg::STAT_UPDATED) |-> count != '0)
		else $error("update reported on empty table");

	// a stalled result word stays valid and holds its status and count
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(count)))
		else $error("result word changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind sorted_leaf_insert_table_core slit_checker u_slit_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status   (status),
	.key_out  (key_out),
	.value_out(value_out),
	.count    (count),
	.pready   (pready)
);

// ----- tb/sorted_leaf_insert_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_leaf_insert_table_core_tb
// Self-checking bench for the sorted key/value leaf table. A short directed
// table covers the empty, full and lowered-limit corners. Phases of random
// put, read, pop and unused-code traffic follow, each at its own entry limit,
// under bursty request flow and result back-pressure. Every result word is
// checked field by field against the directed row or a behavioural table copy.
// ----------------------------------------------------------------------------
module sorted_leaf_insert_table_core_tb;

	localparam longint unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned     PHASE_ITEMS   = 130;
	localparam int unsigned     NUM_PHASES    = 8;
	localparam int unsigned     TAIL_CYCLES   = 60;
	localparam logic [1:0]      REQ_UNUSED    = 2'd3;

	typedef struct packed {
		logic [1:0]  req;
		logic [31:0] key;
		logic [31:0] value;
		logic [3:0]  index;
	} leaf_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] key_out;
		logic [31:0] value_out;
		logic [4:0]  count;
	} leaf_resp_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [4:0] limit;
		leaf_req_t  rq;
		bit         typed;
		leaf_resp_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [31:0] key;
	logic [31:0] value;
	logic [3:0]  index;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] key_out;
	logic [31:0] value_out;
	logic [4:0]  count;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// behavioural copy of the table
	logic [31:0] table_keys [slit_pkg::CAPACITY];
	logic [31:0] table_vals [slit_pkg::CAPACITY];
	int unsigned table_count = 0;
	int unsigned table_limit = 16;

	leaf_resp_t      resp_due [$];
	dir_row_t        dir_rows [$];
	int unsigned     mismatches = 0;
	longint unsigned cycles = 0;
	int unsigned     burst_left = 0;

	sorted_leaf_insert_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.key       (key),
		.value     (value),
		.index     (index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.key_out   (key_out),
		.value_out (value_out),
		.count     (count),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic leaf_resp_t leaf_predict(input leaf_req_t r);
		leaf_resp_t  o;
		int unsigned pos;
		int unsigned lim;
		int unsigned i;
		o = '0;
		o.status = slit_pkg::STAT_RANGE;
		lim = (table_limit > slit_pkg::CAPACITY) ? slit_pkg::CAPACITY : table_limit;
		case (r.req)
			slit_pkg::REQ_PUT: begin
				pos = 0;
				while (pos < table_count && table_keys[pos] < r.key)
					pos++;
				if (pos < table_count && table_keys[pos] == r.key) begin
					table_vals[pos] = r.value;
					o.status = slit_pkg::STAT_UPDATED;
				end else if (table_count >= lim) begin
					o.status = slit_pkg::STAT_FULL;
				end else begin
					for (i = table_count; i > pos; i--) begin
						table_keys[i] = table_keys[i-1];
						table_vals[i] = table_vals[i-1];
					end
					table_keys[pos] = r.key;
					table_vals[pos] = r.value;
					table_count++;
					o.status = slit_pkg::STAT_DONE;
				end
			end
			slit_pkg::REQ_READ: begin
				if (r.index < table_count) begin
					o.key_out   = table_keys[r.index];
					o.value_out = table_vals[r.index];
					o.status    = slit_pkg::STAT_DONE;
				end
			end
			slit_pkg::REQ_POP: begin
				if (table_count > 0) begin
					table_count--;
					o.status = slit_pkg::STAT_DONE;
				end
			end
			default: ;
		endcase
		o.count = slit_pkg::CNT_W'(table_count);
		return o;
	endfunction

	// keys biased towards hits, neighbours of stored keys and the extremes
	function automatic logic [31:0] pick_key();
		logic [31:0] k;
		k = $urandom;
		case ($urandom_range(0, 7))
			0, 1: begin
				if (table_count > 0)
					k = table_keys[$urandom_range(0, table_count - 1)];
			end
			2: begin
				if (table_count > 0)
					k = table_keys[$urandom_range(0, table_count - 1)]
						+ ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
			end
			3, 4: k = $urandom_range(0, 63);
			5: begin
				case ($urandom_range(0, 2))
					0: k = 32'h0000_0000;
					1: k = 32'hFFFF_FFFF;
					default: k = 32'hFFFF_FFFE;
				endcase
			end
			default: ;
		endcase
		return k;
	endfunction

	function automatic leaf_req_t rand_req(input int unsigned put_pct);
		leaf_req_t   r;
		int unsigned roll;
		r.key   = $urandom;
		r.value = $urandom;
		r.index = 4'($urandom_range(0, 15));
		roll = $urandom_range(0, 99);
		if (roll < put_pct) begin
			r.req = slit_pkg::REQ_PUT;
			r.key = pick_key();
		end else if (roll < 96) begin
			if ($urandom_range(0, 99) < 60) begin
				r.req = slit_pkg::REQ_READ;
				if (table_count > 0 && $urandom_range(0, 3) != 0)
					r.index = 4'($urandom_range(0, table_count - 1));
			end else begin
				r.req = slit_pkg::REQ_POP;
			end
		end else begin
			r.req = REQ_UNUSED;
		end
		return r;
	endfunction

	// expected columns are ignored when typed is 0
	function automatic void add_item(input bit typed, input logic [1:0] rq,
			input logic [31:0] k, input logic [31:0] v, input logic [3:0] ix,
			input logic [1:0] st, input logic [31:0] ko, input logic [31:0] vo,
			input logic [4:0] n);
		dir_row_t row;
		row.kind  = ROW_REQ;
		row.limit = '0;
		row.rq    = '{req: rq, key: k, value: v, index: ix};
		row.typed = typed;
		row.want  = '{status: st, key_out: ko, value_out: vo, count: n};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [4:0] lim);
		dir_row_t row;
		row.kind  = ROW_CFG;
		row.limit = lim;
		row.rq    = '0;
		row.typed = 1'b0;
		row.want  = '0;
		dir_rows.push_back(row);
	endfunction

	task automatic send_item(input leaf_req_t r, input bit typed, input leaf_resp_t want);
		int unsigned gap;
		leaf_resp_t  pred;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			// roughly one burst in four follows its predecessor back to back
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		req_type <= r.req;
		key      <= r.key;
		value    <= r.value;
		index    <= r.index;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		pred = leaf_predict(r);
		resp_due.push_back(typed ? want : pred);
	endtask

	// drop valid and hold until every outstanding word has been returned
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (resp_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [4:0] lim);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= slit_pkg::REG_ADDR_MAX_ENTRIES;
		pwdata  <= 32'(lim);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		table_limit = 32'(lim);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// receiver back-pressure: runs of always-ready, coin-flip, sparse and periodic
	initial begin
		int unsigned run;
		int unsigned mode;
		int unsigned k;
		out_ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			run  = $urandom_range(4, 60);
			for (k = 0; k < run; k++) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= (k % 5 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		leaf_resp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (resp_due.size() == 0) begin
				$error("result word with nothing expected: status %0d count %0d",
					status, count);
				mismatches++;
			end else begin
				want = resp_due.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (key_out !== want.key_out) begin
					$error("key_out: expected %h, got %h", want.key_out, key_out);
					mismatches++;
				end
				if (value_out !== want.value_out) begin
					$error("value_out: expected %h, got %h", want.value_out, value_out);
					mismatches++;
				end
				if (count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned p;
		int unsigned n;
		int unsigned lim;
		int unsigned put_pct;
		int unsigned phase_lim [NUM_PHASES];
		int unsigned phase_put [NUM_PHASES];
		phase_lim = '{16, 31, 4, 2, 0, 1, 9, 16};
		phase_put = '{70, 55, 50, 45, 40, 50, 55, 65};

		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		req_type <= slit_pkg::REQ_PUT;
		key      <= '0;
		value    <= '0;
		index    <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// columns: typed, req, key, value, idx, status, key_out, value_out, cnt
		add_item(1, slit_pkg::REQ_READ, 0, 0, 0, slit_pkg::STAT_RANGE, 0, 0, 0);
		add_item(1, slit_pkg::REQ_POP, 0, 0, 0, slit_pkg::STAT_RANGE, 0, 0, 0);
		add_item(1, REQ_UNUSED, 0, 0, 0, slit_pkg::STAT_RANGE, 0, 0, 0);
		add_item(1, slit_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
			slit_pkg::STAT_DONE, 0, 0, 1);
		add_item(1, slit_pkg::REQ_PUT, 0, 0, 0, slit_pkg::STAT_DONE, 0, 0, 2);
		add_item(1, slit_pkg::REQ_PUT, 32'h8000_0000, 32'h0000_1234, 0,
			slit_pkg::STAT_DONE, 0, 0, 3);
		add_item(1, slit_pkg::REQ_READ, 0, 0, 0, slit_pkg::STAT_DONE, 0, 0, 3);
		add_item(1, slit_pkg::REQ_READ, 0, 0, 2, slit_pkg::STAT_DONE,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 3);
		add_item(0, slit_pkg::REQ_READ, 0, 0, 1, slit_pkg::STAT_DONE, 0, 0, 0);
		add_item(1, slit_pkg::REQ_PUT, 0, 32'hA5A5_A5A5, 0, slit_pkg::STAT_UPDATED,
			0, 0, 3);
		add_item(1, slit_pkg::REQ_READ, 0, 0, 3, slit_pkg::STAT_RANGE, 0, 0, 3);
		add_item(1, slit_pkg::REQ_READ, 0, 0, 15, slit_pkg::STAT_RANGE, 0, 0, 3);
		add_cfg(5'd3);
		add_item(1, slit_pkg::REQ_PUT, 5, 32'h5A5A_5A5A, 0, slit_pkg::STAT_FULL,
			0, 0, 3);
		add_item(1, slit_pkg::REQ_PUT, 32'h8000_0000, 7, 0, slit_pkg::STAT_UPDATED,
			0, 0, 3);
		// limit now below the count: entries stay, inserts refused
		add_cfg(5'd1);
		add_item(1, slit_pkg::REQ_PUT, 9, 9, 0, slit_pkg::STAT_FULL, 0, 0, 3);
		add_item(1, slit_pkg::REQ_POP, 0, 0, 0, slit_pkg::STAT_DONE, 0, 0, 2);
		add_item(1, slit_pkg::REQ_POP, 0, 0, 0, slit_pkg::STAT_DONE, 0, 0, 1);
		add_item(1, slit_pkg::REQ_PUT, 9, 9, 0, slit_pkg::STAT_FULL, 0, 0, 1);
		add_item(0, slit_pkg::REQ_READ, 0, 0, 0, slit_pkg::STAT_DONE, 0, 0, 0);
		add_cfg(5'd0);
		add_item(1, slit_pkg::REQ_PUT, 0, 1, 0, slit_pkg::STAT_UPDATED, 0, 0, 1);
		add_item(1, slit_pkg::REQ_POP, 0, 0, 0, slit_pkg::STAT_DONE, 0, 0, 0);
		add_item(1, slit_pkg::REQ_PUT, 1, 1, 0, slit_pkg::STAT_FULL, 0, 0, 0);
		add_cfg(5'd31);
		add_item(1, slit_pkg::REQ_PUT, 7, 70, 0, slit_pkg::STAT_DONE, 0, 0, 1);
		add_item(1, slit_pkg::REQ_PUT, 3, 30, 0, slit_pkg::STAT_DONE, 0, 0, 2);
		add_item(0, slit_pkg::REQ_READ, 0, 0, 1, slit_pkg::STAT_DONE, 0, 0, 0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain();
				cfg_write(dir_rows[i].limit);
			end else begin
				send_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (p = 0; p < NUM_PHASES; p++) begin
			lim     = (p == 6) ? $urandom_range(3, 15) : phase_lim[p];
			put_pct = phase_put[p];
			drain();
			cfg_write(5'(lim));
			for (n = 0; n < PHASE_ITEMS; n++)
				send_item(rand_req(put_pct), 1'b0, '0);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && resp_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
